// ===== design/skped_pkg.sv =====
`default_nettype none
package skped_pkg;
    localparam int SampleWidth = 24;
    localparam int FracBits = 16;
    localparam int CoefBits = 16;
    localparam int LevelWidth = SampleWidth - 1;
    localparam int CoefWidth = CoefBits + 1;
    localparam int KneeShift = 2 * FracBits + 2 - 16;
    localparam int SqWidth = 2 * SampleWidth + 1;
    localparam int SqrtSteps = SampleWidth + 1;
    localparam logic [LevelWidth-1:0] LevelMax = '1;

    typedef enum logic [2:0] {
        REG_POLARITY = 3'd0,
        REG_THRESHOLD = 3'd1,
        REG_KNEE_WIDTH = 3'd2,
        REG_KNEE_GAIN = 3'd3,
        REG_ATTACK = 3'd4,
        REG_DECAY = 3'd5,
        REG_DECAY_INSTANT = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic signed [SampleWidth-1:0] re;
        logic signed [SampleWidth-1:0] im;
    } item_t;
endpackage
`default_nettype wire

// ===== design/skped_fifo.sv =====
`default_nettype none
module skped_fifo
    import skped_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr_valid,
    output logic       wr_stall,
    input  wire item_t wr_data,
    output logic       rd_valid,
    input  wire logic  rd_take,
    output item_t      rd_data
);
    item_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign wr_stall = cnt_reg == 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_valid && !wr_stall)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_valid && !wr_stall)
            begin
                wp_reg <= !wp_reg;
            end
            if (rd_take && rd_valid)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, wr_valid && !wr_stall}
                - {1'b0, rd_take && rd_valid};
        end
    end
endmodule
`default_nettype wire

// ===== design/skped_core.sv =====
`default_nettype none
module skped_core
    import skped_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_take,
    input  wire item_t                         in_data,
    input  wire logic                          neg_pol,
    input  wire logic signed [SampleWidth-1:0] thr,
    input  wire logic [LevelWidth-1:0]         knee_w,
    input  wire logic [31:0]                   knee_g,
    input  wire logic [CoefWidth-1:0]          att,
    input  wire logic [CoefWidth-1:0]          dec,
    input  wire logic                          dec_inst,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [SampleWidth-1:0]      out_env,
    output logic                               out_err
);
    typedef enum logic [3:0] {
        S_IDLE, S_SQRT, S_CLASS, S_KSQ, S_KMUL, S_KSUM, S_FOLLOW, S_UPD, S_OUT
    } state_t;

    localparam int SW2 = SampleWidth + 2;

    state_t state_reg;
    logic [LevelWidth-1:0] held_reg;
    logic err_reg, cplx_reg;
    logic [SqWidth-1:0] num_reg, rt_reg, bit_reg;
    logic [4:0] step_reg;
    logic signed [SW2-1:0] s_reg, t_reg;
    logic [LevelWidth-1:0] d_reg;
    logic [SampleWidth:0] x2_reg;
    logic [2*SampleWidth+1:0] sq_reg;
    logic [2*SampleWidth+17:0] pa_reg, pb_reg;
    logic [LevelWidth+CoefWidth-1:0] prod_reg;
    logic up_reg;

    logic err_now;
    logic [SampleWidth-1:0] ar, ai;
    logic [SqWidth-1:0] trial;
    logic signed [SW2+1:0] s2, tlo, thi, diff;
    logic [2*SampleWidth+17:0] lomask, q;

    assign err_now = neg_pol ? (thr > 0) : (thr < 0);
    assign ar = in_data.re[SampleWidth-1] ? SampleWidth'(-in_data.re) : in_data.re;
    assign ai = in_data.im[SampleWidth-1] ? SampleWidth'(-in_data.im) : in_data.im;
    assign trial = rt_reg + bit_reg;
    assign s2 = {s_reg[SW2-1], s_reg, 1'b0};
    assign tlo = {t_reg[SW2-1], t_reg, 1'b0} - (SW2+2)'(knee_w);
    assign thi = {t_reg[SW2-1], t_reg, 1'b0} + (SW2+2)'(knee_w);
    assign diff = (SW2+2)'(s_reg - t_reg);
    assign lomask = (2*SampleWidth+18)'((64'd1 << KneeShift) - 1);
    assign q = (pa_reg >> KneeShift)
        + (((pa_reg & lomask) + (pb_reg >> 16)) >> KneeShift);

    assign in_take = state_reg == S_IDLE && in_valid;
    assign out_valid = state_reg == S_OUT;
    assign out_env = neg_pol ? -SampleWidth'(held_reg) : SampleWidth'(held_reg);
    assign out_err = err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            held_reg <= '0;
            err_reg <= 1'b0;
            cplx_reg <= 1'b0;
            num_reg <= '0;
            rt_reg <= '0;
            bit_reg <= '0;
            step_reg <= '0;
            s_reg <= '0;
            t_reg <= '0;
            d_reg <= '0;
            x2_reg <= '0;
            sq_reg <= '0;
            pa_reg <= '0;
            pb_reg <= '0;
            prod_reg <= '0;
            up_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        err_reg <= err_now;
                        cplx_reg <= in_data.im != 0;
                        num_reg <= SqWidth'((2*SampleWidth)'(ar) * (2*SampleWidth)'(ar))
                            + SqWidth'((2*SampleWidth)'(ai) * (2*SampleWidth)'(ai));
                        rt_reg <= '0;
                        bit_reg <= SqWidth'(1) << (2 * (SqrtSteps - 1));
                        step_reg <= '0;
                        s_reg <= neg_pol ? -SW2'(in_data.re) : SW2'(in_data.re);
                        t_reg <= neg_pol ? -SW2'(thr) : SW2'(thr);
                        state_reg <= err_now ? S_UPD : (in_data.im != 0 ? S_SQRT : S_CLASS);
                    end
                end
                S_SQRT:
                begin
                    if (num_reg >= trial)
                    begin
                        num_reg <= num_reg - trial;
                        rt_reg <= (rt_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        rt_reg <= rt_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'(SqrtSteps - 1))
                    begin
                        state_reg <= S_CLASS;
                    end
                end
                S_CLASS:
                begin
                    if (cplx_reg)
                    begin
                        s_reg <= (rt_reg > SqWidth'(LevelMax)) ? SW2'(LevelMax)
                            : SW2'(rt_reg);
                        state_reg <= S_CLASS;
                        cplx_reg <= 1'b0;
                    end
                    else
                    begin
                        state_reg <= S_FOLLOW;
                        if (knee_w == 0)
                        begin
                            d_reg <= (s_reg < t_reg) ? '0
                                : (diff > (SW2+2)'(LevelMax)) ? LevelMax
                                : LevelWidth'(diff);
                        end
                        else if (s2 < tlo)
                        begin
                            d_reg <= '0;
                        end
                        else if (s2 > thi)
                        begin
                            d_reg <= (diff > (SW2+2)'(LevelMax)) ? LevelMax
                                : LevelWidth'(diff);
                        end
                        else
                        begin
                            x2_reg <= (SampleWidth+1)'(s2 - tlo);
                            state_reg <= S_KSQ;
                        end
                    end
                end
                S_KSQ:
                begin
                    sq_reg <= x2_reg * x2_reg;
                    state_reg <= S_KMUL;
                end
                S_KMUL:
                begin
                    pa_reg <= sq_reg * knee_g[31:16];
                    pb_reg <= sq_reg * knee_g[15:0];
                    state_reg <= S_KSUM;
                end
                S_KSUM:
                begin
                    d_reg <= (q > (2*SampleWidth+18)'(LevelMax)) ? LevelMax
                        : LevelWidth'(q);
                    state_reg <= S_FOLLOW;
                end
                S_FOLLOW:
                begin
                    if (d_reg > held_reg)
                    begin
                        up_reg <= 1'b1;
                        prod_reg <= (d_reg - held_reg) * att;
                    end
                    else
                    begin
                        up_reg <= 1'b0;
                        prod_reg <= held_reg * dec;
                    end
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    if (!err_reg)
                    begin
                        if (d_reg > held_reg)
                        begin
                            held_reg <= (att[CoefBits]) ? d_reg
                                : held_reg + LevelWidth'(prod_reg >> CoefBits);
                        end
                        else if (d_reg < held_reg)
                        begin
                            if (dec_inst)
                            begin
                                held_reg <= d_reg;
                            end
                            else if ((prod_reg >> CoefBits)
                                < (LevelWidth+CoefWidth)'(held_reg) && !up_reg)
                            begin
                                held_reg <= LevelWidth'(prod_reg >> CoefBits);
                            end
                        end
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== design/soft_knee_peak_envelope_detector.sv =====
`default_nettype none
// Peak envelope detector with soft knee. A real item passes through classing,
// the envelope follower, the update and the output; one that falls inside
// the knee also takes the three-step knee multiply, and a complex item first
// takes the 25-step square root. An item with a threshold error goes straight
// to the update and the output. Items are carried out one at a time: the core
// takes a new item only once the last result is accepted, so a result stall
// holds it. A two-entry queue lets the front accept items while the back works.
module soft_knee_peak_envelope_detector
    import skped_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [2:0]                    cfg_index,
    input  wire logic [31:0]                   cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [SampleWidth-1:0] sample_real,
    input  wire logic signed [SampleWidth-1:0] sample_imag,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [SampleWidth-1:0]      envelope,
    output logic                               threshold_error
);
    logic pol_reg, dinst_reg;
    logic signed [SampleWidth-1:0] thr_reg;
    logic [LevelWidth-1:0] kw_reg;
    logic [31:0] kg_reg;
    logic [CoefWidth-1:0] att_reg, dec_reg;
    item_t in_item, q_item;
    logic q_valid, q_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pol_reg <= 1'b0;
            thr_reg <= '0;
            kw_reg <= '0;
            kg_reg <= '0;
            att_reg <= CoefWidth'(65536);
            dec_reg <= CoefWidth'(62259);
            dinst_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_POLARITY: pol_reg <= cfg_data[0];
                REG_THRESHOLD: thr_reg <= cfg_data[SampleWidth-1:0];
                REG_KNEE_WIDTH: kw_reg <= cfg_data[LevelWidth-1:0];
                REG_KNEE_GAIN: kg_reg <= cfg_data;
                REG_ATTACK: att_reg <= cfg_data[CoefWidth-1:0];
                REG_DECAY: dec_reg <= cfg_data[CoefWidth-1:0];
                REG_DECAY_INSTANT: dinst_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign in_item.re = sample_real;
    assign in_item.im = sample_imag;

    skped_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(in_valid), .wr_stall(in_stall), .wr_data(in_item),
        .rd_valid(q_valid), .rd_take(q_take), .rd_data(q_item)
    );

    skped_core u_core (
        .clk(clk), .rst_n(rst_n),
        .in_valid(q_valid), .in_take(q_take), .in_data(q_item),
        .neg_pol(pol_reg), .thr(thr_reg), .knee_w(kw_reg), .knee_g(kg_reg),
        .att(att_reg), .dec(dec_reg), .dec_inst(dinst_reg),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_env(envelope), .out_err(threshold_error)
    );
endmodule
`default_nettype wire
